// File: rtl/s5hs_pkg.sv
package s5hs_pkg;

    // Depth of the command queue between the classifier and the sequencer.
    localparam int QUEUE_DEPTH = 4;

    // Request codes carried on the input.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_HOST  = 2'd1;
    localparam logic [1:0] REQ_RECV  = 2'd2;

    // Link status codes.
    localparam logic [1:0] STAT_BUSY = 2'd0;
    localparam logic [1:0] STAT_CONN = 2'd1;
    localparam logic [1:0] STAT_FAIL = 2'd2;

    // Protocol bytes.
    localparam logic [7:0] SOCKS_VER    = 8'h05;
    localparam logic [7:0] NMETHODS     = 8'h01;
    localparam logic [7:0] METH_NOAUTH  = 8'h00;
    localparam logic [7:0] CMD_CONNECT  = 8'h01;
    localparam logic [7:0] RSV_BYTE     = 8'h00;
    localparam logic [7:0] REP_OK       = 8'h00;
    localparam logic [7:0] ATYP_IPV4    = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN  = 8'h03;
    localparam logic [7:0] ATYP_IPV6    = 8'h04;

    // Bytes to discard after the address type: address plus two port bytes.
    localparam logic [8:0] SKIP_IPV4 = 9'd6;
    localparam logic [8:0] SKIP_IPV6 = 9'd18;
    localparam logic [8:0] SKIP_PORT = 9'd2;

    // What the sequencer must send for one accepted item.
    typedef enum logic [2:0] {
        K_NONE,
        K_GREET,
        K_HEADER,
        K_HOSTB,
        K_HOSTLAST
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] port;
        logic [1:0]  status;
    } t_cmd;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_txb;

    // Number of results a command expands into, less one.
    function automatic logic [2:0] kind_last(input t_kind kind);
        logic [2:0] n;
        case (kind)
            K_GREET:    n = 3'd2;
            K_HEADER:   n = 3'd4;
            K_HOSTLAST: n = 3'd2;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

    // Byte sent at position idx of a command.
    function automatic t_txb result_byte(input t_kind kind, input logic [2:0] idx,
                                         input logic [7:0] data, input logic [15:0] port);
        t_txb r;
        r = '{valid: 1'b1, data: 8'h00};
        case (kind)
            K_GREET: begin
                case (idx)
                    3'd0:    r.data = SOCKS_VER;
                    3'd1:    r.data = NMETHODS;
                    default: r.data = METH_NOAUTH;
                endcase
            end
            K_HEADER: begin
                case (idx)
                    3'd0:    r.data = SOCKS_VER;
                    3'd1:    r.data = CMD_CONNECT;
                    3'd2:    r.data = RSV_BYTE;
                    3'd3:    r.data = ATYP_DOMAIN;
                    default: r.data = data;
                endcase
            end
            K_HOSTB: r.data = data;
            K_HOSTLAST: begin
                case (idx)
                    3'd0:    r.data = data;
                    3'd1:    r.data = port[15:8];
                    default: r.data = port[7:0];
                endcase
            end
            default: r = '{valid: 1'b0, data: 8'h00};
        endcase
        return r;
    endfunction

endpackage

// File: rtl/socks5_connect_handshake_unit.sv
// An accepted item passes the command queue and then the output register before its
// first result shows (o_empty low). Throughput: one item per cycle on the input while
// the command queue has room; one result per cycle on the output while it is popped,
// and an item causes one to five results, set by the single result sequencer.
// Reset: synchronous, active low; clears the handshake phase, the queue and the
// output register, so the unit comes up idle, not full and empty.
module socks5_connect_handshake_unit #(
    parameter int QueueDepth = s5hs_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input side, queue style: the transaction completes when push is high
    // and full is low.
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_host_length,
    input  logic [15:0] i_target_port,
    input  logic [7:0]  i_data_byte,
    // Result side: the oldest result is shown while empty is low and is
    // taken when pop is high.
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic [1:0]  o_link_status,
    output logic        o_run_last
);

    // The front end owns the protocol state. Every accepted item updates the
    // phase in the same cycle and turns into one compact command that tells
    // the back end which bytes to send and what status to report.
    s5hs_pkg::t_cmd front_cmd;
    s5hs_pkg::t_cmd head_cmd;
    logic           accept;
    logic           head_valid;
    logic           head_done;

    assign accept = i_push && !o_full;

    s5hs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req_type    (i_req_type),
        .i_host_length (i_host_length),
        .i_target_port (i_target_port),
        .i_data_byte   (i_data_byte),
        .o_cmd         (front_cmd)
    );

    // The command queue decouples the two halves, so the front end keeps
    // taking received bytes while a long greeting or header is still being
    // sent out.
    s5hs_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (front_cmd),
        .o_full  (o_full),
        .i_rd    (head_done),
        .o_valid (head_valid),
        .o_rdata (head_cmd)
    );

    // The back end expands the head command into its results, one per cycle when not
    // stalled by pop, into an output register that refills in the same cycle it is popped.
    s5hs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (head_valid),
        .i_cmd         (head_cmd),
        .o_cmd_done    (head_done),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_link_status (o_link_status),
        .o_run_last    (o_run_last)
    );

endmodule

// File: rtl/s5hs_front.sv
module s5hs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_host_length,
    input  logic [15:0]       i_target_port,
    input  logic [7:0]        i_data_byte,
    output s5hs_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_MVER, PH_MMETH, PH_HOST, PH_RVER, PH_RREP,
        PH_RRSV, PH_RATYP, PH_RDLEN, PH_RSKIP, PH_DONE, PH_FAIL
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_name_rem, n_name_rem;
    logic [7:0]  r_name_len, n_name_len;
    logic [15:0] r_port_hold, n_port_hold;
    logic [8:0]  r_discard, n_discard;
    logic [7:0]  rem_dec;
    logic [8:0]  disc_dec;

    assign rem_dec  = r_name_rem - 8'd1;
    assign disc_dec = r_discard - 9'd1;

    always_comb begin
        n_phase     = r_phase;
        n_name_rem  = r_name_rem;
        n_name_len  = r_name_len;
        n_port_hold = r_port_hold;
        n_discard   = r_discard;
        o_cmd.kind  = s5hs_pkg::K_NONE;
        o_cmd.data  = i_data_byte;
        o_cmd.port  = r_port_hold;
        case (i_req_type)
            s5hs_pkg::REQ_START: begin
                if (i_host_length == 8'd0) begin
                    n_phase = PH_FAIL;
                end else begin
                    n_name_len  = i_host_length;
                    n_name_rem  = 8'd0;
                    n_port_hold = i_target_port;
                    n_discard   = 9'd0;
                    o_cmd.kind  = s5hs_pkg::K_GREET;
                    n_phase     = PH_MVER;
                end
            end
            s5hs_pkg::REQ_HOST: begin
                if (r_phase == PH_HOST) begin
                    n_name_rem = rem_dec;
                    if (rem_dec == 8'd0) begin
                        o_cmd.kind = s5hs_pkg::K_HOSTLAST;
                        n_phase    = PH_RVER;
                    end else begin
                        o_cmd.kind = s5hs_pkg::K_HOSTB;
                    end
                end
            end
            s5hs_pkg::REQ_RECV: begin
                case (r_phase)
                    PH_MVER: begin
                        n_phase = (i_data_byte == s5hs_pkg::SOCKS_VER) ? PH_MMETH : PH_FAIL;
                    end
                    PH_MMETH: begin
                        if (i_data_byte != s5hs_pkg::METH_NOAUTH) begin
                            n_phase = PH_FAIL;
                        end else begin
                            o_cmd.kind = s5hs_pkg::K_HEADER;
                            o_cmd.data = r_name_len;
                            n_name_rem = r_name_len;
                            n_phase    = PH_HOST;
                        end
                    end
                    PH_RVER: begin
                        n_phase = (i_data_byte == s5hs_pkg::SOCKS_VER) ? PH_RREP : PH_FAIL;
                    end
                    PH_RREP: begin
                        n_phase = (i_data_byte == s5hs_pkg::REP_OK) ? PH_RRSV : PH_FAIL;
                    end
                    PH_RRSV: begin
                        n_phase = PH_RATYP;
                    end
                    PH_RATYP: begin
                        if (i_data_byte == s5hs_pkg::ATYP_IPV4) begin
                            n_discard = s5hs_pkg::SKIP_IPV4;
                            n_phase   = PH_RSKIP;
                        end else if (i_data_byte == s5hs_pkg::ATYP_IPV6) begin
                            n_discard = s5hs_pkg::SKIP_IPV6;
                            n_phase   = PH_RSKIP;
                        end else if (i_data_byte == s5hs_pkg::ATYP_DOMAIN) begin
                            n_phase = PH_RDLEN;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                    PH_RDLEN: begin
                        n_discard = {1'b0, i_data_byte} + s5hs_pkg::SKIP_PORT;
                        n_phase   = PH_RSKIP;
                    end
                    PH_RSKIP: begin
                        n_discard = disc_dec;
                        if (disc_dec == 9'd0) begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: n_phase = PH_FAIL;
                endcase
            end
            default: ;
        endcase
        case (n_phase)
            PH_DONE: o_cmd.status = s5hs_pkg::STAT_CONN;
            PH_FAIL: o_cmd.status = s5hs_pkg::STAT_FAIL;
            default: o_cmd.status = s5hs_pkg::STAT_BUSY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_name_rem  <= 8'd0;
            r_name_len  <= 8'd0;
            r_port_hold <= 16'd0;
            r_discard   <= 9'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_name_rem  <= n_name_rem;
            r_name_len  <= n_name_len;
            r_port_hold <= n_port_hold;
            r_discard   <= n_discard;
        end
    end

endmodule

// File: rtl/s5hs_queue.sv
module s5hs_queue #(
    parameter int Depth = s5hs_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  s5hs_pkg::t_cmd i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output s5hs_pkg::t_cmd o_rdata
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    s5hs_pkg::t_cmd r_mem [Depth];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_wr, do_rd;

    assign o_full  = (r_count == CW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/s5hs_back.sv
module s5hs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  s5hs_pkg::t_cmd i_cmd,
    output logic           o_cmd_done,
    output logic           o_empty,
    input  logic           i_pop,
    output logic           o_tx_valid,
    output logic [7:0]     o_tx_byte,
    output logic [1:0]     o_link_status,
    output logic           o_run_last
);

    logic             r_out_valid;
    logic [2:0]       r_idx;
    logic             r_tx_valid;
    logic [7:0]       r_tx_byte;
    logic [1:0]       r_status;
    logic             r_last;
    logic             load;
    logic             is_last;
    s5hs_pkg::t_txb   txb;

    // A new result enters the output register when it is free or being taken.
    assign load       = i_cmd_valid && (!r_out_valid || i_pop);
    assign is_last    = (r_idx == s5hs_pkg::kind_last(i_cmd.kind));
    assign o_cmd_done = load && is_last;
    assign txb        = s5hs_pkg::result_byte(i_cmd.kind, r_idx, i_cmd.data, i_cmd.port);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx_valid <= txb.valid;
            r_tx_byte  <= txb.data;
            r_status   <= i_cmd.status;
            r_last     <= is_last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_tx_valid    = r_tx_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_link_status = r_status;
    assign o_run_last    = r_last;

endmodule

// File: rtl/s5hs_checker.sv
module s5hs_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic        o_tx_valid,
    input logic [7:0]  o_tx_byte,
    input logic [1:0]  o_link_status,
    input logic        o_run_last
);

    // Reset leaves both sides idle.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("unit not idle after reset");

    // A result that carries no byte has a zero byte.
    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_tx_valid) |-> (o_tx_byte == 8'h00))
        else $error("nonzero byte on a result without a byte");

    // The status code is always one of the three defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_link_status == s5hs_pkg::STAT_BUSY) ||
                      (o_link_status == s5hs_pkg::STAT_CONN) ||
                      (o_link_status == s5hs_pkg::STAT_FAIL)))
        else $error("undefined link status");

    // Results of one item follow each other back to back with one status.
    a_item_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_run_last) |=>
            (!o_empty && (o_link_status == $past(o_link_status))))
        else $error("results of one item broken up or status changed");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_tx_byte) && $stable(o_run_last)))
        else $error("stalled result changed");

endmodule

bind socks5_connect_handshake_unit s5hs_assertions u_s5hs_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_full        (o_full),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_tx_valid    (o_tx_valid),
    .o_tx_byte     (o_tx_byte),
    .o_link_status (o_link_status),
    .o_run_last    (o_run_last)
);

// File: sim/s5hs_checker.sv
`timescale 1ns / 100ps

module s5hs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_host_length,
    input  logic [15:0] i_target_port,
    input  logic [7:0]  i_data_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_tx_valid,
    input  logic [7:0]  i_tx_byte,
    input  logic [1:0]  i_link_status,
    input  logic        i_run_last,
    output int          o_mismatches,
    output int          o_pending
);

    typedef enum logic [3:0] {
        HS_IDLE,
        HS_MVER,
        HS_MMETH,
        HS_HOST,
        HS_RVER,
        HS_RREP,
        HS_RRSV,
        HS_RATYP,
        HS_RDLEN,
        HS_RSKIP,
        HS_DONE,
        HS_FAIL
    } t_hs_phase;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] link_status;
        logic       run_last;
    } t_tx_result;

    t_hs_phase   hs_phase;
    logic [7:0]  name_left;
    logic [7:0]  name_len;
    logic [15:0] port_hold;
    logic [8:0]  discard_left;
    t_tx_result  expected_tx[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0d ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    // Advances the handshake by one accepted transaction and queues the results it causes.
    task automatic predict_handshake(input logic [1:0] req, input logic [7:0] hlen,
                                     input logic [15:0] port, input logic [7:0] data);
        logic [7:0] sent [0:4];
        int         n_sent;
        logic [1:0] status;
        n_sent = 0;
        case (req)
            s5hs_pkg::REQ_START: begin
                if (hlen == 8'd0) begin
                    hs_phase = HS_FAIL;
                end else begin
                    name_len     = hlen;
                    name_left    = 8'd0;
                    port_hold    = port;
                    discard_left = 9'd0;
                    sent[0]      = s5hs_pkg::SOCKS_VER;
                    sent[1]      = s5hs_pkg::NMETHODS;
                    sent[2]      = s5hs_pkg::METH_NOAUTH;
                    n_sent       = 3;
                    hs_phase     = HS_MVER;
                end
            end
            s5hs_pkg::REQ_HOST: begin
                if (hs_phase == HS_HOST) begin
                    sent[0]   = data;
                    n_sent    = 1;
                    name_left = name_left - 8'd1;
                    if (name_left == 8'd0) begin
                        sent[1]  = port_hold[15:8];
                        sent[2]  = port_hold[7:0];
                        n_sent   = 3;
                        hs_phase = HS_RVER;
                    end
                end
            end
            s5hs_pkg::REQ_RECV: begin
                case (hs_phase)
                    HS_MVER:  hs_phase = (data == s5hs_pkg::SOCKS_VER) ? HS_MMETH : HS_FAIL;
                    HS_MMETH: begin
                        if (data != s5hs_pkg::METH_NOAUTH) begin
                            hs_phase = HS_FAIL;
                        end else begin
                            sent[0]   = s5hs_pkg::SOCKS_VER;
                            sent[1]   = s5hs_pkg::CMD_CONNECT;
                            sent[2]   = s5hs_pkg::RSV_BYTE;
                            sent[3]   = s5hs_pkg::ATYP_DOMAIN;
                            sent[4]   = name_len;
                            n_sent    = 5;
                            name_left = name_len;
                            hs_phase  = HS_HOST;
                        end
                    end
                    HS_RVER:  hs_phase = (data == s5hs_pkg::SOCKS_VER) ? HS_RREP : HS_FAIL;
                    HS_RREP:  hs_phase = (data == s5hs_pkg::REP_OK) ? HS_RRSV : HS_FAIL;
                    HS_RRSV:  hs_phase = HS_RATYP;
                    HS_RATYP: begin
                        if (data == s5hs_pkg::ATYP_IPV4) begin
                            discard_left = s5hs_pkg::SKIP_IPV4;
                            hs_phase     = HS_RSKIP;
                        end else if (data == s5hs_pkg::ATYP_IPV6) begin
                            discard_left = s5hs_pkg::SKIP_IPV6;
                            hs_phase     = HS_RSKIP;
                        end else if (data == s5hs_pkg::ATYP_DOMAIN) begin
                            hs_phase = HS_RDLEN;
                        end else begin
                            hs_phase = HS_FAIL;
                        end
                    end
                    HS_RDLEN: begin
                        discard_left = {1'b0, data} + s5hs_pkg::SKIP_PORT;
                        hs_phase     = HS_RSKIP;
                    end
                    HS_RSKIP: begin
                        discard_left = discard_left - 9'd1;
                        if (discard_left == 9'd0) hs_phase = HS_DONE;
                    end
                    default:  hs_phase = HS_FAIL;
                endcase
            end
            default: ;
        endcase

        if (hs_phase == HS_DONE) status = s5hs_pkg::STAT_CONN;
        else if (hs_phase == HS_FAIL) status = s5hs_pkg::STAT_FAIL;
        else status = s5hs_pkg::STAT_BUSY;

        if (n_sent == 0) begin
            expected_tx.push_back('{tx_valid: 1'b0, tx_byte: 8'h00,
                                    link_status: status, run_last: 1'b1});
        end else begin
            for (int k = 0; k < n_sent; k++) begin
                expected_tx.push_back('{tx_valid: 1'b1, tx_byte: sent[k],
                                        link_status: status, run_last: (k == n_sent - 1)});
            end
        end
    endtask

    task automatic check_result();
        t_tx_result want;
        if (expected_tx.size() == 0) begin
            report_mismatch("result with nothing expected", i_tx_byte, 8'h00);
            return;
        end
        want = expected_tx.pop_front();
        if (i_tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", 8'(i_tx_valid), 8'(want.tx_valid));
        if (i_tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", i_tx_byte, want.tx_byte);
        if (i_link_status !== want.link_status)
            report_mismatch("link_status", 8'(i_link_status), 8'(want.link_status));
        if (i_run_last !== want.run_last)
            report_mismatch("run_last", 8'(i_run_last), 8'(want.run_last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hs_phase     = HS_IDLE;
            name_left    = 8'd0;
            name_len     = 8'd0;
            port_hold    = 16'd0;
            discard_left = 9'd0;
            expected_tx.delete();
        end else begin
            if (i_push && !i_full)
                predict_handshake(i_req_type, i_host_length, i_target_port, i_data_byte);
            if (i_pop && !i_empty)
                check_result();
        end
        o_pending <= expected_tx.size();
    end

endmodule

// File: sim/tb_socks5_connect_handshake_unit.sv
`timescale 1ns / 100ps

module tb_socks5_connect_handshake_unit;

    localparam int CLK_PERIOD = 12;
    // A request type the block has no use for; it must be ignored.
    localparam logic [1:0] REQ_NONE = 2'd3;
    // Cycles in which the receiver refuses results while the sender keeps pushing.
    localparam int HOLD_CYCLES = 80;
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int QUIET_LIMIT = 5000;
    // Items per idling phase of the random part.
    localparam int PHASE_ITEMS = 25;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [1:0]  i_req_type = s5hs_pkg::REQ_START;
    logic [7:0]  i_host_length = 8'h00;
    logic [15:0] i_target_port = 16'h0000;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_pop = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic [1:0]  o_link_status;
    logic        o_run_last;

    int mismatches;
    int pending;

    // Idling percentages of both sides, changed by the stimulus between phases.
    int push_idle_pct = 0;
    int pop_idle_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    // The long receiver hold-off is requested here and counted in the receiver process.
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    socks5_connect_handshake_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_req_type   (i_req_type),
        .i_host_length(i_host_length),
        .i_target_port(i_target_port),
        .i_data_byte  (i_data_byte),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_link_status(o_link_status),
        .o_run_last   (o_run_last)
    );

    // The checker sees both channels exactly as the block does, predicts every
    // transaction and compares each popped result with the oldest expectation.
    s5hs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_full       (o_full),
        .i_req_type   (i_req_type),
        .i_host_length(i_host_length),
        .i_target_port(i_target_port),
        .i_data_byte  (i_data_byte),
        .i_empty      (o_empty),
        .i_pop        (i_pop),
        .i_tx_valid   (o_tx_valid),
        .i_tx_byte    (o_tx_byte),
        .i_link_status(o_link_status),
        .i_run_last   (o_run_last),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Receiver side. Pop is redrawn every cycle from the current idling rate,
    // except during the one long hold-off, which is counted down right here so
    // that the sender is free to keep offering items and fill the block up.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= ($urandom_range(0, 99) >= pop_idle_pct);
        end
    end

    // Watchdog: any accepted transaction on either side proves progress. A run
    // that goes quiet for too long is hung, whatever the reason.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item and returns at the clock edge that accepts it. All calls
    // happen right after a rising edge, so each drive lands as one nonblocking
    // assignment in that time step; push is lowered only for a real gap.
    task automatic send_item(input logic [1:0] req, input logic [7:0] hlen,
                             input logic [15:0] port, input logic [7:0] data);
        while ($urandom_range(0, 99) < push_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_req_type    <= req;
        i_host_length <= hlen;
        i_target_port <= port;
        i_data_byte   <= data;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        if (req != REQ_NONE) items_sent++;
    endtask

    // The fields a request type does not use carry random values, so the block
    // is also shown to ignore them.
    task automatic send_start(input logic [7:0] hlen, input logic [15:0] port);
        send_item(s5hs_pkg::REQ_START, hlen, port, 8'($urandom));
    endtask

    task automatic send_host(input logic [7:0] data);
        send_item(s5hs_pkg::REQ_HOST, 8'($urandom), 16'($urandom), data);
    endtask

    task automatic send_recv(input logic [7:0] data);
        send_item(s5hs_pkg::REQ_RECV, 8'($urandom), 16'($urandom), data);
    endtask

    // Stops offering and waits until every expected result has been popped.
    // The first edge lets the checker's count catch up with the last push.
    task automatic drain_results();
        i_push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // A byte from the proxy, now and then replaced by garbage so that broken
    // exchanges show up among the well-formed ones.
    function automatic logic [7:0] proxy_byte(input logic [7:0] data);
        return ($urandom_range(0, 15) == 0) ? 8'($urandom) : data;
    endfunction

    // One connect attempt from start to the end of the proxy reply, with random
    // content. Long names and long bound addresses are cut short and the
    // attempt is abandoned, so that the next start has to take over mid-flight.
    task automatic run_session();
        logic [7:0] name_len;
        logic [7:0] atyp;
        logic [7:0] addr_len;
        int         n_host;
        int         n_skip;
        int         pick;
        name_len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 6));
        n_host = (name_len > 8'd8) ? 8 : int'(name_len);
        send_start(name_len, 16'($urandom));
        send_recv(proxy_byte(s5hs_pkg::SOCKS_VER));
        send_recv(proxy_byte(s5hs_pkg::METH_NOAUTH));
        repeat (n_host) send_host(8'($urandom));
        if (n_host != int'(name_len)) return;
        send_recv(proxy_byte(s5hs_pkg::SOCKS_VER));
        send_recv(proxy_byte(s5hs_pkg::REP_OK));
        send_recv(8'($urandom));
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            send_recv(proxy_byte(s5hs_pkg::ATYP_IPV4));
            n_skip = int'(s5hs_pkg::SKIP_IPV4);
        end else if (pick < 6) begin
            send_recv(proxy_byte(s5hs_pkg::ATYP_IPV6));
            n_skip = int'(s5hs_pkg::SKIP_IPV6);
        end else if (pick < 9) begin
            send_recv(proxy_byte(s5hs_pkg::ATYP_DOMAIN));
            addr_len = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            send_recv(addr_len);
            n_skip = int'(addr_len) + int'(s5hs_pkg::SKIP_PORT);
            if (n_skip > 12) n_skip = 12;
        end else begin
            // Mostly an address type the client does not know.
            atyp = 8'($urandom);
            send_recv(atyp);
            n_skip = int'(s5hs_pkg::SKIP_PORT);
        end
        repeat (n_skip) send_recv(8'($urandom));
    endtask

    // Fully random item of any request type, ignored ones included.
    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic run_random_phase();
        int goal;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) begin
            if ($urandom_range(0, 3) == 0) send_noise();
            else run_session();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First phase: the sender idles now and then, the receiver often.
        push_idle_pct = 22;
        pop_idle_pct  = 54;

        // Directed part. Idle block: an unused request type and a stray host
        // byte are ignored, while a byte from the proxy fails the link.
        send_item(REQ_NONE, 8'hff, 16'hffff, 8'hff);
        send_host(8'h41);
        send_recv(s5hs_pkg::SOCKS_VER);
        // A start with an empty name fails at once.
        send_start(8'h00, 16'hffff);
        // Shortest complete connect: one name byte, extreme port, a domain
        // reply with an empty name, so only the two port bytes are skipped.
        send_start(8'h01, 16'hffff);
        send_recv(s5hs_pkg::SOCKS_VER);
        send_recv(s5hs_pkg::METH_NOAUTH);
        send_host(8'hff);
        send_host(8'h00);
        send_recv(s5hs_pkg::SOCKS_VER);
        send_recv(s5hs_pkg::REP_OK);
        send_recv(8'hff);
        send_recv(s5hs_pkg::ATYP_DOMAIN);
        send_recv(8'h00);
        send_recv(8'h12);
        send_recv(8'h34);
        // Once connected, any further proxy byte is a protocol error.
        send_recv(8'h00);
        // Longest name and zero port, then a wrong version in the method reply.
        send_start(8'hff, 16'h0000);
        send_recv(8'h04);
        // Start again over a failed link, then refuse on the method byte.
        send_start(8'h02, 16'h1234);
        send_recv(s5hs_pkg::SOCKS_VER);
        send_recv(8'h01);
        // The failed state holds against host bytes and unused request types.
        send_host(8'h5a);
        send_item(REQ_NONE, 8'h00, 16'h0000, 8'h00);

        run_random_phase();
        drain_results();

        // Second phase: the roles swap.
        push_idle_pct = 54;
        pop_idle_pct  = 22;
        run_random_phase();
        drain_results();

        // Last phase: no idling at all, opened by one long receiver hold-off
        // while items keep coming, so that the block fills up and pushes back.
        push_idle_pct = 0;
        pop_idle_pct  = 0;
        hold_req      = 1'b1;
        run_random_phase();
        drain_results();

        // Let the pipeline settle so a stray late result would still be caught.
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
